### rtl/xmodem_crc_page_receiver_assert.svh
// ---------------------------------------------------------------------------
// XMODEM-CRC page receiver assertion macros
// Concurrent assertion helpers; they compile to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef XMODEM_CRC_PAGE_RECEIVER_ASSERT_SVH
`define XMODEM_CRC_PAGE_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

`define XCPR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define XCPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define XCPR_ASSERT(lbl, clk, rst_n, prop, msg)

`define XCPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/xcpr_pkg.sv
// ---------------------------------------------------------------------------
// XMODEM-CRC page receiver package
// Shared constants, types and the CRC-16 byte update.
// ---------------------------------------------------------------------------
package xcpr_pkg;

    localparam int XCPR_PAGE_COUNT = 512;
    localparam int PAGE_BYTES      = 256;
    localparam int PAGE_WORD_W     = 64;
    localparam int PAGE_WORDS      = PAGE_BYTES / (PAGE_WORD_W / 8);
    localparam int WORD_AW         = $clog2(PAGE_WORDS);

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 2;

    // Protocol characters
    localparam logic [7:0] CH_SOH  = 8'h01;
    localparam logic [7:0] CH_EOT  = 8'h04;
    localparam logic [7:0] CH_ACK  = 8'h06;
    localparam logic [7:0] CH_NAK  = 8'h15;
    localparam logic [7:0] CH_POLL = 8'h43;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Packet byte positions after the leading SOH
    localparam logic [7:0] POS_BLK      = 8'd0;
    localparam logic [7:0] POS_BLK_INV  = 8'd1;
    localparam logic [7:0] POS_DATA0    = 8'd2;
    localparam logic [7:0] POS_DATA_END = 8'd129;
    localparam logic [7:0] POS_CRC_HI   = 8'd130;
    localparam logic [7:0] POS_CRC_LO   = 8'd131;

    localparam logic [9:0] TICK_MAX = 10'd1023;
    localparam logic [8:0] FILL_FULL = 9'd256;
    localparam logic [8:0] FILL_HALF = 9'd128;

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_START_KEY     = 2'd0;
    localparam logic [1:0] CFG_START_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_POLL_INTERVAL = 2'd2;

    localparam logic [7:0] RST_START_KEY     = 8'd100;
    localparam logic [9:0] RST_START_TIMEOUT = 10'd500;
    localparam logic [9:0] RST_POLL_INTERVAL = 10'd100;

    // Result kinds
    localparam logic [1:0] RK_TX   = 2'd0;
    localparam logic [1:0] RK_WORD = 2'd1;
    localparam logic [1:0] RK_FIN  = 2'd2;

    // Result sequence requested by the controller for one input item.
    // Stages run in the order tx_a, flush, tx_b, fin.
    typedef struct packed {
        logic       tx_a;
        logic       flush;
        logic       tx_b;
        logic       fin;
        logic [7:0] tx_byte;
        logic       fin_status;
        logic [8:0] valid_cnt;
        logic [8:0] page;
    } t_cmd;

    // Byte write into the page memory
    typedef struct packed {
        logic                   en;
        logic [WORD_AW-1:0]     addr;
        logic [PAGE_WORD_W/8-1:0] be;
        logic [PAGE_WORD_W-1:0] data;
    } t_memwr;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

### rtl/xcpr_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port with byte enables, one read port with registered data.
// ---------------------------------------------------------------------------
module xcpr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH/8-1:0]       i_wbe,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    localparam int LANES = WIDTH / 8;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int l = 0; l < LANES; l++) begin
                if (i_wbe[l]) begin
                    mem[i_waddr][l*8 +: 8] <= i_wdata[l*8 +: 8];
                end
            end
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/xcpr_ctrl.sv
// ---------------------------------------------------------------------------
// XMODEM-CRC receive controller
// Protocol phases, tick counting, packet checks, CRC and page fill writes.
// ---------------------------------------------------------------------------
`include "xmodem_crc_page_receiver_assert.svh"

module xcpr_ctrl import xcpr_pkg::*; #(
    parameter int PAGE_COUNT = XCPR_PAGE_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic [9:0] i_cfg_wdata,
    input  logic       i_accept,
    input  logic       i_kind,
    input  logic [7:0] i_rx_byte,
    input  logic       i_rx_error,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    output t_memwr     o_memwr
);

    localparam int PC_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    typedef enum logic [4:0] {
        PH_KEY    = 5'b00001,
        PH_POLL   = 5'b00010,
        PH_PACKET = 5'b00100,
        PH_NEXT   = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [9:0]      r_tick, n_tick;
    logic [7:0]      r_exp, n_exp;
    logic [7:0]      r_pos, n_pos;
    logic            r_hdr_good, n_hdr_good;
    logic [15:0]     r_crc, n_crc;
    logic [7:0]      r_crc_hi, n_crc_hi;
    logic            r_fill_half, n_fill_half;
    logic [PC_W-1:0] r_page, n_page;
    logic [7:0]      r_key;
    logic [9:0]      r_timeout;
    logic [9:0]      r_interval;

    logic            rx;
    logic [9:0]      tick_inc;
    logic [7:0]      data_pos;
    logic [7:0]      fill_off;
    logic [PC_W-1:0] page_inc;
    logic            pkt_good;

    always_comb begin
        rx       = !i_kind && !i_rx_error;
        tick_inc = (r_tick == TICK_MAX) ? r_tick : r_tick + 10'd1;
        data_pos = r_pos - POS_DATA0;
        fill_off = {r_fill_half, data_pos[6:0]};
        page_inc = (r_page == PC_W'(PAGE_COUNT - 1)) ? '0 : r_page + PC_W'(1);
        pkt_good = r_hdr_good && (r_crc == {r_crc_hi, i_rx_byte});

        n_phase     = r_phase;
        n_tick      = r_tick;
        n_exp       = r_exp;
        n_pos       = r_pos;
        n_hdr_good  = r_hdr_good;
        n_crc       = r_crc;
        n_crc_hi    = r_crc_hi;
        n_fill_half = r_fill_half;
        n_page      = r_page;

        o_cmd_valid    = 1'b0;
        o_cmd          = '0;
        o_cmd.page     = 9'(r_page);
        o_memwr        = '0;
        o_memwr.addr   = fill_off[7:3];
        o_memwr.be     = 8'b1 << fill_off[2:0];
        o_memwr.data   = {8{i_rx_byte}};

        if (i_accept) begin
            case (r_phase)
                PH_KEY: begin
                    if (i_kind) begin
                        n_tick = tick_inc;
                        if (tick_inc > r_timeout) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.fin   = 1'b1;
                            n_phase     = PH_DONE;
                        end
                    end else if (rx && i_rx_byte == r_key) begin
                        n_phase = PH_POLL;
                    end
                end
                PH_POLL: begin
                    // The tick count carries over from the key wait, so the
                    // first poll may go out early.
                    if (i_kind) begin
                        n_tick = tick_inc;
                        if (tick_inc > r_interval) begin
                            o_cmd_valid   = 1'b1;
                            o_cmd.tx_a    = 1'b1;
                            o_cmd.tx_byte = CH_POLL;
                            n_tick        = '0;
                        end
                    end else if (rx && i_rx_byte == CH_SOH) begin
                        n_phase    = PH_PACKET;
                        n_pos      = '0;
                        n_hdr_good = 1'b1;
                        n_crc      = '0;
                        n_crc_hi   = '0;
                    end
                end
                PH_NEXT: begin
                    if (rx) begin
                        if (i_rx_byte == CH_EOT) begin
                            o_cmd_valid      = 1'b1;
                            o_cmd.tx_a       = 1'b1;
                            o_cmd.tx_byte    = CH_ACK;
                            o_cmd.flush      = r_fill_half;
                            o_cmd.valid_cnt  = FILL_HALF;
                            o_cmd.fin        = 1'b1;
                            o_cmd.fin_status = 1'b1;
                            if (r_fill_half) begin
                                n_page = page_inc;
                            end
                            n_fill_half = 1'b0;
                            n_phase     = PH_DONE;
                        end else begin
                            // Any other byte opens the next packet.
                            n_phase    = PH_PACKET;
                            n_pos      = '0;
                            n_hdr_good = 1'b1;
                            n_crc      = '0;
                            n_crc_hi   = '0;
                        end
                    end
                end
                PH_PACKET: begin
                    if (rx) begin
                        n_pos = r_pos + 8'd1;
                        if (r_pos == POS_BLK) begin
                            if (i_rx_byte != r_exp) begin
                                n_hdr_good = 1'b0;
                            end
                        end else if (r_pos == POS_BLK_INV) begin
                            if (~i_rx_byte != r_exp) begin
                                n_hdr_good = 1'b0;
                            end
                        end else if (r_pos inside {[POS_DATA0:POS_DATA_END]}) begin
                            o_memwr.en = 1'b1;
                            n_crc      = crc16_byte(r_crc, i_rx_byte);
                        end else if (r_pos == POS_CRC_HI) begin
                            n_crc_hi = i_rx_byte;
                        end else begin
                            o_cmd_valid = 1'b1;
                            if (pkt_good) begin
                                o_cmd.tx_byte = CH_ACK;
                                if (r_fill_half) begin
                                    // Second block completes the page: words
                                    // go out ahead of the ACK.
                                    o_cmd.flush     = 1'b1;
                                    o_cmd.valid_cnt = FILL_FULL;
                                    o_cmd.tx_b      = 1'b1;
                                    n_page          = page_inc;
                                    n_fill_half     = 1'b0;
                                end else begin
                                    o_cmd.tx_a  = 1'b1;
                                    n_fill_half = 1'b1;
                                end
                                n_exp = r_exp + 8'd1;
                            end else begin
                                o_cmd.tx_a    = 1'b1;
                                o_cmd.tx_byte = CH_NAK;
                            end
                            n_phase = PH_NEXT;
                            n_pos   = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_KEY;
            r_tick      <= '0;
            r_exp       <= 8'd1;
            r_pos       <= '0;
            r_hdr_good  <= 1'b1;
            r_crc       <= '0;
            r_crc_hi    <= '0;
            r_fill_half <= 1'b0;
            r_page      <= '0;
            r_key       <= RST_START_KEY;
            r_timeout   <= RST_START_TIMEOUT;
            r_interval  <= RST_POLL_INTERVAL;
        end else begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_exp       <= n_exp;
            r_pos       <= n_pos;
            r_hdr_good  <= n_hdr_good;
            r_crc       <= n_crc;
            r_crc_hi    <= n_crc_hi;
            r_fill_half <= n_fill_half;
            r_page      <= n_page;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_START_KEY:     r_key      <= i_cfg_wdata[7:0];
                    CFG_START_TIMEOUT: r_timeout  <= i_cfg_wdata;
                    CFG_POLL_INTERVAL: r_interval <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    `XCPR_ASSERT_IMP(a_done_sticky, i_clk, i_rst_n, r_phase == PH_DONE,
        1'b1 ##1 r_phase == PH_DONE, "finished state was left")
    `XCPR_ASSERT(a_pos_range, i_clk, i_rst_n, r_pos <= POS_CRC_LO,
        "packet position beyond packet end")
    `XCPR_ASSERT_IMP(a_one_lane, i_clk, i_rst_n, o_memwr.en,
        $onehot(o_memwr.be) && !o_cmd_valid, "page write is not a single byte")

endmodule

### rtl/xcpr_emit.sv
// ---------------------------------------------------------------------------
// XMODEM-CRC result sequencer
// Holds one result sequence and presents its transfers: transmit bytes,
// page words read from the page memory, and the finish status.
// ---------------------------------------------------------------------------
`include "xmodem_crc_page_receiver_assert.svh"

module xcpr_emit import xcpr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  t_cmd                   i_cmd,
    output logic                   o_free,
    output logic                   o_rd_en,
    output logic [WORD_AW-1:0]     o_rd_addr,
    input  logic [PAGE_WORD_W-1:0] i_rd_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic [OUT_TUSER_W-1:0] o_tuser,
    output logic                   o_tlast
);

    typedef enum logic [4:0] {
        ES_IDLE  = 5'b00001,
        ES_TXA   = 5'b00010,
        ES_WORDS = 5'b00100,
        ES_TXB   = 5'b01000,
        ES_FIN   = 5'b10000
    } t_estate;

    localparam logic [WORD_AW-1:0] WORD_LAST = WORD_AW'(PAGE_WORDS - 1);

    t_estate            r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [WORD_AW-1:0] r_word, n_word;

    t_estate                stage_next;
    t_estate                stage_first;
    logic                   is_last;
    logic                   take;
    logic [PAGE_WORD_W-1:0] word_data;
    logic [7:0]             byte_addr;

    function automatic t_estate after_words(input t_cmd c);
        return c.tx_b ? ES_TXB : (c.fin ? ES_FIN : ES_IDLE);
    endfunction

    function automatic t_estate after_txa(input t_cmd c);
        return c.flush ? ES_WORDS : after_words(c);
    endfunction

    always_comb begin
        case (r_state)
            ES_TXA:   stage_next = after_txa(r_cmd);
            ES_WORDS: stage_next = (r_word == WORD_LAST) ? after_words(r_cmd) : ES_WORDS;
            ES_TXB:   stage_next = r_cmd.fin ? ES_FIN : ES_IDLE;
            default:  stage_next = ES_IDLE;
        endcase
        stage_first = i_cmd.tx_a ? ES_TXA : after_txa(i_cmd);

        o_valid = (r_state != ES_IDLE);
        is_last = (stage_next == ES_IDLE);
        take    = o_valid && i_ready;
        o_free  = !o_valid || (take && is_last);

        n_state = r_state;
        n_cmd   = r_cmd;
        n_word  = r_word;
        if (o_free) begin
            n_state = i_cmd_valid ? stage_first : ES_IDLE;
            n_cmd   = i_cmd;
            n_word  = '0;
        end else if (take) begin
            n_state = stage_next;
            n_word  = r_word + WORD_AW'(1);
        end

        // Word 0 is read ahead outside the word stage so that the first
        // page word is ready as soon as that stage begins.
        o_rd_en   = (r_state != ES_WORDS) || i_ready;
        o_rd_addr = (r_state == ES_WORDS) ? r_word + WORD_AW'(1) : '0;

        // Bytes past the filled part of the page read as erased flash.
        for (int b = 0; b < PAGE_WORD_W / 8; b++) begin
            byte_addr = {r_word, 3'(b)};
            word_data[b*8 +: 8] = ({1'b0, byte_addr} < r_cmd.valid_cnt) ?
                                  i_rd_data[b*8 +: 8] : 8'hFF;
        end

        o_tdata = '0;
        o_tuser = RK_TX;
        case (r_state)
            ES_TXA, ES_TXB: begin
                o_tdata[7:0] = r_cmd.tx_byte;
            end
            ES_WORDS: begin
                o_tuser        = RK_WORD;
                o_tdata[16:8]  = r_cmd.page;
                o_tdata[21:17] = r_word;
                o_tdata[85:22] = word_data;
            end
            ES_FIN: begin
                o_tuser     = RK_FIN;
                o_tdata[86] = r_cmd.fin_status;
            end
            default: begin
            end
        endcase
        o_tlast = o_valid && is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ES_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_word <= n_word;
    end

    `XCPR_ASSERT_IMP(a_word_step, i_clk, i_rst_n,
        (r_state == ES_WORDS) && take && (r_word != WORD_LAST),
        1'b1 ##1 ((r_state == ES_WORDS) && (r_word == $past(r_word) + WORD_AW'(1))),
        "page words out of order")
    `XCPR_ASSERT_IMP(a_fin_final, i_clk, i_rst_n, (r_state == ES_FIN) && take,
        1'b1 ##1 !o_valid, "result after finish")

endmodule

### rtl/xmodem_crc_page_receiver.sv
// ---------------------------------------------------------------------------
// XMODEM-CRC page receiver
// Serial download receiver that turns XMODEM-CRC packets into flash pages.
// ---------------------------------------------------------------------------
// The block takes one input transfer per clock while its output is free: a
// received byte or a timer tick. Inputs that give a single result (a poll,
// ACK, NAK or the timeout finish) also keep that rate, since the output
// register is reloaded in the cycle its transfer completes. An EOT with no
// partial page gives two results and holds the input until both are taken.
// A page flush gives 33 or 34 results and holds the input until the last is
// taken; the page memory's one read port delivers one 64-bit word per cycle
// while the output is ready. The page memory has no reset or clearing pass.
`include "xmodem_crc_page_receiver_assert.svh"

module xmodem_crc_page_receiver import xcpr_pkg::*; #(
    parameter int PAGE_COUNT = XCPR_PAGE_COUNT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [1:0]             i_cfg_index,
    input  logic [9:0]             i_cfg_wdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // rx_byte
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,   // kind, rx_error
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tx_byte, page_index, word_index, word_data, finish_status, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser,   // result_kind
    output logic                   o_m_axis_tlast
);

    logic                   e_free;
    logic                   cmd_valid;
    t_cmd                   cmd;
    t_memwr                 memwr;
    logic                   rd_en;
    logic [WORD_AW-1:0]     rd_addr;
    logic [PAGE_WORD_W-1:0] rd_data;
    logic                   in_accept;

    assign o_s_axis_tready = e_free;
    assign in_accept       = i_s_axis_tvalid && e_free;

    xcpr_ctrl #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_accept),
        .i_kind      (i_s_axis_tuser[0]),
        .i_rx_byte   (i_s_axis_tdata[7:0]),
        .i_rx_error  (i_s_axis_tuser[1]),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .o_memwr     (memwr)
    );

    xcpr_ram #(
        .WIDTH (PAGE_WORD_W),
        .DEPTH (PAGE_WORDS)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (memwr.en),
        .i_waddr (memwr.addr),
        .i_wbe   (memwr.be),
        .i_wdata (memwr.data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    xcpr_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_free      (e_free),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata),
        .o_tuser     (o_m_axis_tuser),
        .o_tlast     (o_m_axis_tlast)
    );

    // A page write while a sequence is still going out would corrupt a flush.
    `XCPR_ASSERT_IMP(a_write_when_free, i_clk, i_rst_n, memwr.en, e_free,
        "page write while results are pending")

endmodule
